[sv/gbfa_pkg.sv]
// ----------------------------------------------------------------------------
// gbfa_pkg
// Shared types and constants for the grid bucket feature admission block.
// ----------------------------------------------------------------------------
package gbfa_pkg;

    // field widths
    localparam int COORD_W   = 12;
    localparam int PBL_W     = 4;
    localparam int TOTAL_W   = 10;
    localparam int ID_W      = 32;
    localparam int BUCKET_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // defaults
    localparam int BUCKETS_PER_AXIS_DEF = 10;
    localparam logic [COORD_W-1:0] IMG_W_RST = 12'd1241;
    localparam logic [COORD_W-1:0] IMG_H_RST = 12'd376;
    localparam logic [PBL_W-1:0]   PBL_RST   = 4'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_RST = 10'd200;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMG_W = 3'd0,
        REG_IMG_H = 3'd1,
        REG_PBL   = 3'd2,
        REG_TOTAL = 3'd3
    } t_reg_idx;

    // configuration seen by the front and the back
    typedef struct packed {
        logic [COORD_W-1:0] img_w;
        logic [COORD_W-1:0] img_h;
        logic [PBL_W-1:0]   pbl;
        logic [TOTAL_W-1:0] total;
    } t_cfg;

    // queue status toward its producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[sv/grid_bucket_feature_admission.sv]
// ----------------------------------------------------------------------------
// grid_bucket_feature_admission
// Admits feature points under per-cell and per-frame limits on a square grid.
//
//   channel   dir  handshake                 payload
//   input     in   i_valid / o_ready         i_pixel_x, i_pixel_y, i_first_of_frame
//   result    out  o_valid / i_ready         o_accepted, o_assigned_id,
//                                            o_bucket_index, o_frame_full
//   config    in   i_cfg_wr_en (no wait)     i_cfg_index, i_cfg_data
//
// in the front a word passes through accept, cell size multiply, one boundary
// step per grid line and queue push. the back adds a counter read-modify-write,
// overlapped with the next word's front work. reset is synchronous and needs
// no clearing pass.
// a stalled result holds the back; the front keeps working until the queue fills.
// ----------------------------------------------------------------------------
module grid_bucket_feature_admission
    import gbfa_pkg::*;
#(
    parameter int BUCKETS_PER_AXIS = BUCKETS_PER_AXIS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [COORD_W-1:0]   i_pixel_x,
    input  logic [COORD_W-1:0]   i_pixel_y,
    input  logic                 i_first_of_frame,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_accepted,
    output logic [ID_W-1:0]      o_assigned_id,
    output logic [BUCKET_W-1:0]  o_bucket_index,
    output logic                 o_frame_full,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int CELL_W = $clog2(BUCKETS_PER_AXIS * BUCKETS_PER_AXIS);

    t_cfg            r_cfg;
    t_q_stat         w_q_stat;
    logic            w_push, w_pop;
    logic [CELL_W:0] w_push_data, w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.img_w <= IMG_W_RST;
            r_cfg.img_h <= IMG_H_RST;
            r_cfg.pbl   <= PBL_RST;
            r_cfg.total <= TOTAL_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_IMG_W: r_cfg.img_w <= i_cfg_data;
                REG_IMG_H: r_cfg.img_h <= i_cfg_data;
                REG_PBL:   r_cfg.pbl   <= i_cfg_data[PBL_W-1:0];
                REG_TOTAL: r_cfg.total <= i_cfg_data[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gbfa_front #(
        .BUCKETS_PER_AXIS (BUCKETS_PER_AXIS),
        .CELL_W           (CELL_W)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_first_of_frame (i_first_of_frame),
        .i_q_stat         (w_q_stat),
        .o_push           (w_push),
        .o_push_data      (w_push_data)
    );

    gbfa_queue #(
        .DATA_W  (CELL_W + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_stat  (w_q_stat)
    );

    gbfa_back #(
        .BUCKETS_PER_AXIS (BUCKETS_PER_AXIS),
        .CELL_W           (CELL_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_stat       (w_q_stat),
        .i_q_data       (w_q_data),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_accepted     (o_accepted),
        .o_assigned_id  (o_assigned_id),
        .o_bucket_index (o_bucket_index),
        .o_frame_full   (o_frame_full)
    );

endmodule

[sv/gbfa_front.sv]
// ----------------------------------------------------------------------------
// gbfa_front
// Accepts a point and works out its grid cell: cell size by reciprocal
// multiply, then one threshold step per cell boundary on both axes.
// ----------------------------------------------------------------------------
module gbfa_front
    import gbfa_pkg::*;
#(
    parameter int BUCKETS_PER_AXIS = BUCKETS_PER_AXIS_DEF,
    parameter int CELL_W           = $clog2(BUCKETS_PER_AXIS * BUCKETS_PER_AXIS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_pixel_x,
    input  logic [COORD_W-1:0] i_pixel_y,
    input  logic               i_first_of_frame,
    input  t_q_stat            i_q_stat,
    output logic               o_push,
    output logic [CELL_W:0]    o_push_data
);

    localparam int KW     = $clog2(BUCKETS_PER_AXIS);
    localparam int SHIFT  = COORD_W + KW;
    localparam int RECIP  = ((1 << SHIFT) + BUCKETS_PER_AXIS - 1) / BUCKETS_PER_AXIS;
    localparam int PROD_W = SHIFT + COORD_W;
    localparam logic [KW-1:0] LAST_K = KW'(BUCKETS_PER_AXIS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SIZE = 4'b0010,
        S_SCAN = 4'b0100,
        S_PUSH = 4'b1000
    } t_fstate;

    t_fstate            r_state, n_state;
    logic [COORD_W-1:0] r_x, r_y;
    logic               r_first;
    logic [COORD_W-1:0] r_size_x, r_size_y;
    logic [COORD_W-1:0] r_acc_x, r_acc_y;
    logic [KW-1:0]      r_col, r_row, r_k;

    logic [PROD_W-1:0]  w_prod_x, w_prod_y;
    logic [COORD_W-1:0] w_size_x, w_size_y;
    logic [CELL_W-1:0]  w_cell;

    // floor(extent / grid) exact for 12-bit extents
    assign w_prod_x = PROD_W'(i_cfg.img_w) * PROD_W'(RECIP);
    assign w_prod_y = PROD_W'(i_cfg.img_h) * PROD_W'(RECIP);
    assign w_size_x = w_prod_x[SHIFT +: COORD_W];
    assign w_size_y = w_prod_y[SHIFT +: COORD_W];

    assign w_cell = CELL_W'(r_row) * CELL_W'(BUCKETS_PER_AXIS) + CELL_W'(r_col);

    assign o_ready     = (r_state == S_IDLE);
    assign o_push      = (r_state == S_PUSH) && !i_q_stat.full;
    assign o_push_data = {r_first, w_cell};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_SIZE;
            S_SIZE: n_state = S_SCAN;
            S_SCAN: if (r_k == LAST_K) n_state = S_PUSH;
            S_PUSH: if (!i_q_stat.full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_x     <= i_pixel_x;
                    r_y     <= i_pixel_y;
                    r_first <= i_first_of_frame;
                end
            end
            S_SIZE: begin
                r_size_x <= w_size_x;
                r_size_y <= w_size_y;
                r_acc_x  <= w_size_x;
                r_acc_y  <= w_size_y;
                r_col    <= '0;
                r_row    <= '0;
                r_k      <= KW'(1);
            end
            S_SCAN: begin
                // boundary k sits at k * size; a zero size lands on the last cell
                if (r_x >= r_acc_x) r_col <= r_k;
                if (r_y >= r_acc_y) r_row <= r_k;
                r_acc_x <= r_acc_x + r_size_x;
                r_acc_y <= r_acc_y + r_size_y;
                r_k     <= r_k + KW'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

[sv/gbfa_queue.sv]
// ----------------------------------------------------------------------------
// gbfa_queue
// Two-entry queue of classified points between front and back.
// ----------------------------------------------------------------------------
module gbfa_queue
    import gbfa_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output t_q_stat           o_stat
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    as_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full || i_pop)
        else $error("push into full queue");
    as_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
    as_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count did not follow push");

endmodule

[sv/gbfa_back.sv]
// ----------------------------------------------------------------------------
// gbfa_back
// Per-cell counter read-modify-write, frame and id counters, result register.
// ----------------------------------------------------------------------------
module gbfa_back
    import gbfa_pkg::*;
#(
    parameter int BUCKETS_PER_AXIS = BUCKETS_PER_AXIS_DEF,
    parameter int CELL_W           = $clog2(BUCKETS_PER_AXIS * BUCKETS_PER_AXIS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_q_stat             i_q_stat,
    input  logic [CELL_W:0]     i_q_data,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_accepted,
    output logic [ID_W-1:0]     o_assigned_id,
    output logic [BUCKET_W-1:0] o_bucket_index,
    output logic                o_frame_full
);

    localparam int CELLS = BUCKETS_PER_AXIS * BUCKETS_PER_AXIS;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_UPD  = 2'b10
    } t_bstate;

    t_bstate             r_state, n_state;
    logic [PBL_W-1:0]    r_mem [CELLS];
    logic [CELLS-1:0]    r_valid;
    logic [PBL_W-1:0]    r_rd;
    logic [CELL_W-1:0]   r_cell;
    logic [TOTAL_W-1:0]  r_frame;
    logic [ID_W-1:0]     r_next_id;

    logic                r_o_valid, r_accepted, r_full;
    logic [ID_W-1:0]     r_id;
    logic [BUCKET_W-1:0] r_bucket;

    logic [CELL_W-1:0]   w_head_cell;
    logic                w_head_first;
    logic [PBL_W-1:0]    w_count;
    logic                w_admit, w_load;
    logic [TOTAL_W-1:0]  w_frame_nxt;
    logic [BUCKET_W+CELL_W-1:0] w_cell_ext;

    assign w_head_cell  = i_q_data[CELL_W-1:0];
    assign w_head_first = i_q_data[CELL_W];

    assign o_pop = (r_state == B_IDLE) && !i_q_stat.empty;

    // a cell not touched since the frame started counts as empty
    assign w_count     = r_valid[r_cell] ? r_rd : '0;
    assign w_admit     = (w_count < i_cfg.pbl) && (r_frame < i_cfg.total);
    assign w_load      = (r_state == B_UPD) && (!r_o_valid || i_ready);
    assign w_frame_nxt = w_admit ? r_frame + TOTAL_W'(1) : r_frame;
    assign w_cell_ext  = (BUCKET_W + CELL_W)'(r_cell);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (o_pop) n_state = B_UPD;
            B_UPD:  if (w_load) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_valid   <= '0;
            r_frame   <= '0;
            r_next_id <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && w_head_first) begin
                r_valid <= '0;
                r_frame <= '0;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
                r_frame   <= w_frame_nxt;
                if (w_admit) begin
                    r_valid[r_cell] <= 1'b1;
                    r_next_id       <= r_next_id + ID_W'(1);
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // counter memory: registered read at pop, write on admit
    always_ff @(posedge i_clk) begin
        if (o_pop) r_rd <= r_mem[w_head_cell];
        if (w_load && w_admit) r_mem[r_cell] <= w_count + PBL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cell <= w_head_cell;
        if (w_load) begin
            r_accepted <= w_admit;
            r_id       <= w_admit ? r_next_id : '0;
            r_bucket   <= w_cell_ext[BUCKET_W-1:0];
            r_full     <= (w_frame_nxt >= i_cfg.total);
        end
    end

    assign o_valid        = r_o_valid;
    assign o_accepted     = r_accepted;
    assign o_assigned_id  = r_id;
    assign o_bucket_index = r_bucket;
    assign o_frame_full   = r_full;

    as_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_admit) |=> r_next_id == $past(r_next_id) + ID_W'(1))
        else $error("id counter did not advance on admit");
    as_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_o_valid)
        else $error("result not presented after load");
    as_reject_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_admit) |=> r_id == '0 && r_next_id == $past(r_next_id))
        else $error("rejected point changed id state");
    as_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_UPD) |-> !o_pop)
        else $error("pop while a point is in flight");

endmodule

[bench/grid_bucket_feature_admission_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_bucket_feature_admission_tb
// Drives feature points through the admission block under random flow control
// and register settings. A local grid and counter predictor builds the expected
// result of every point sent. Each result word is checked against the
// oldest expected one.
// ----------------------------------------------------------------------------
module grid_bucket_feature_admission_tb;
    import gbfa_pkg::*;

    localparam int GRID          = BUCKETS_PER_AXIS_DEF;
    localparam int CELLS         = GRID * GRID;
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic                accepted;
        logic [ID_W-1:0]     assigned_id;
        logic [BUCKET_W-1:0] bucket_index;
        logic                frame_full;
    } t_admit_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [COORD_W-1:0]   i_pixel_x = '0;
    logic [COORD_W-1:0]   i_pixel_y = '0;
    logic                 i_first_of_frame = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_accepted;
    logic [ID_W-1:0]      o_assigned_id;
    logic [BUCKET_W-1:0]  o_bucket_index;
    logic                 o_frame_full;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    // predictor state
    t_cfg               grid_cfg;
    logic [PBL_W-1:0]   cell_fill [CELLS];
    logic [TOTAL_W-1:0] frame_admitted;
    logic [ID_W-1:0]    id_counter;

    t_admit_result expected_results [$];

    int unsigned points_sent     = 0;
    int unsigned points_admitted = 0;
    int unsigned frames_started  = 0;
    int unsigned settings_used   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned quiet_cycles    = 0;

    // flow control knobs
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold     = 0;
    int unsigned rx_gap      = 0;

    grid_bucket_feature_admission dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_first_of_frame (i_first_of_frame),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_accepted       (o_accepted),
        .o_assigned_id    (o_assigned_id),
        .o_bucket_index   (o_bucket_index),
        .o_frame_full     (o_frame_full),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // cell along one axis; a zero cell size puts everything in the last cell
    function automatic int unsigned axis_cell(int unsigned coord, int unsigned extent);
        int unsigned size;
        int unsigned c;
        size = extent / GRID;
        if (size == 0) return GRID - 1;
        c = coord / size;
        return (c > GRID - 1) ? GRID - 1 : c;
    endfunction

    function automatic t_admit_result admit_point(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y,
                                                  logic first);
        t_admit_result r;
        int unsigned   grid_pos;
        logic          admit;
        if (first) begin
            foreach (cell_fill[k]) cell_fill[k] = '0;
            frame_admitted = '0;
        end
        grid_pos = axis_cell(32'(y), 32'(grid_cfg.img_h)) * GRID
                 + axis_cell(32'(x), 32'(grid_cfg.img_w));
        if (grid_pos >= CELLS) grid_pos = CELLS - 1;
        admit = (cell_fill[grid_pos] < grid_cfg.pbl) && (frame_admitted < grid_cfg.total);
        r.accepted    = admit;
        r.assigned_id = '0;
        if (admit) begin
            cell_fill[grid_pos] = cell_fill[grid_pos] + 1'b1;
            frame_admitted      = frame_admitted + 1'b1;
            r.assigned_id       = id_counter;
            id_counter          = id_counter + 1'b1;
        end
        r.bucket_index = BUCKET_W'(grid_pos);
        r.frame_full   = (frame_admitted >= grid_cfg.total);
        return r;
    endfunction

    // append one expected word at the tail of the scoreboard queue
    function automatic void log_expected(t_admit_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // valid is left high after acceptance so back-to-back words need no toggle
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic first);
        int unsigned   gap;
        t_admit_result exp_r;
        gap = tx_quiet ? 0 : draw_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_pixel_x        <= x;
        i_pixel_y        <= y;
        i_first_of_frame <= first;
        do @(posedge i_clk); while (!o_ready);
        exp_r = admit_point(x, y, first);
        log_expected(exp_r);
        if (exp_r.accepted) points_admitted++;
        if (first) frames_started++;
        points_sent++;
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic reconfigure(input int unsigned w, input int unsigned h,
                               input int unsigned pbl, input int unsigned tot);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_IMG_W;
        i_cfg_data  <= CFG_DAT_W'(w);
        @(posedge i_clk);
        i_cfg_index <= REG_IMG_H;
        i_cfg_data  <= CFG_DAT_W'(h);
        @(posedge i_clk);
        i_cfg_index <= REG_PBL;
        i_cfg_data  <= CFG_DAT_W'(pbl);
        @(posedge i_clk);
        i_cfg_index <= REG_TOTAL;
        i_cfg_data  <= CFG_DAT_W'(tot);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        grid_cfg.img_w = COORD_W'(w);
        grid_cfg.img_h = COORD_W'(h);
        grid_cfg.pbl   = PBL_W'(pbl);
        grid_cfg.total = TOTAL_W'(tot);
        settings_used++;
    endtask

    // reset settings: cell 124 x 37 pixels, three per cell
    task automatic test_default_grid();
        send_point(12'd0, 12'd0, 1'b1);
        send_point(12'd0, 12'd0, 1'b0);
        send_point(12'd0, 12'd0, 1'b0);
        send_point(12'd123, 12'd36, 1'b0);      // cell already full
        send_point(12'd124, 12'd37, 1'b0);
        send_point(12'd4095, 12'd4095, 1'b0);   // both axes saturate
        send_point(12'd4095, 12'd0, 1'b0);
        send_point(12'd0, 12'd4095, 1'b0);
        send_point(12'd2730, 12'd1365, 1'b0);
        send_point(12'd0, 12'd0, 1'b1);         // new frame frees the cell again
        send_point(12'd1240, 12'd375, 1'b0);
    endtask

    task automatic test_limit_extremes();
        reconfigure(16, 16, 0, 200);            // no room in any cell
        send_point(12'd5, 12'd5, 1'b1);
        send_point(12'd15, 12'd15, 1'b0);
        reconfigure(4095, 4095, 15, 0);         // no room in the frame
        send_point(12'd0, 12'd0, 1'b1);
        send_point(12'd4095, 12'd4095, 1'b0);
        reconfigure(5, 9, 1, 1);                // image smaller than the grid
        send_point(12'd0, 12'd0, 1'b1);
        send_point(12'd4, 12'd8, 1'b0);
        send_point(12'd4095, 12'd0, 1'b1);
        reconfigure(16, 16, 15, 1023);
        send_point(12'd15, 12'd15, 1'b1);
        send_point(12'd1, 12'd2, 1'b0);
        send_point(12'd1, 12'd2, 1'b0);
    endtask

    task automatic test_backpressure();
        reconfigure(IMG_W_RST, IMG_H_RST, PBL_RST, TOTAL_RST);
        tx_quiet    = 1'b1;
        rx_hold_req = 300;
        for (int k = 0; k < 48; k++)
            send_point(12'($urandom_range(0, 1240)), 12'($urandom_range(0, 375)), k == 0);
        tx_quiet = 1'b0;
        // sender stops until the block has handed everything back
        wait_results_drained();
        for (int k = 0; k < 20; k++)
            send_point(12'($urandom_range(0, 1240)), 12'($urandom_range(0, 375)), 1'b0);
    endtask

    task automatic run_random_phase(input int unsigned w, input int unsigned h,
                                    input int unsigned pbl, input int unsigned tot,
                                    input int unsigned count);
        int unsigned        sent;
        int unsigned        len;
        int unsigned        mode;
        int unsigned        hx;
        int unsigned        hy;
        int unsigned        px;
        int unsigned        py;
        logic               first;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        reconfigure(w, h, pbl, tot);
        sent = 0;
        while (sent < count) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(4, 60);
            mode = $urandom_range(0, 9);
            hx   = $urandom_range(0, w - 1);
            hy   = $urandom_range(0, h - 1);
            for (int k = 0; k < len && sent < count; k++) begin
                // most frames open with a frame start, a few run on from the last
                first = (k == 0) ? ($urandom_range(0, 9) != 0)
                                 : ($urandom_range(0, 49) == 0);
                if (mode < 5) begin
                    px = $urandom_range(0, w - 1);
                    py = $urandom_range(0, h - 1);
                end else if (mode < 8) begin
                    // crowd a couple of cells so the per-cell limit bites
                    px = hx + $urandom_range(0, w / GRID);
                    py = hy + $urandom_range(0, h / GRID);
                end else begin
                    px = $urandom_range(0, 4095);
                    py = $urandom_range(0, 4095);
                end
                x = (px > 4095) ? 12'd4095 : COORD_W'(px);
                y = (py > 4095) ? 12'd4095 : COORD_W'(py);
                send_point(x, y, first);
                sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        run_random_phase(IMG_W_RST, IMG_H_RST, PBL_RST, TOTAL_RST, 280);
        run_random_phase(4095, 4095, 15, 1023, 280);
        run_random_phase(16, 16, 1, 1, 200);
        run_random_phase(640, 480, $urandom_range(1, 15), $urandom_range(20, 300), 280);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_random_phase(200, 100, 2, 7, 260);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        run_random_phase($urandom_range(16, 4095), $urandom_range(16, 4095),
                         $urandom_range(1, 15), $urandom_range(1, 1023), 300);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin : rx_drive
        int unsigned gap;
        if (rx_hold_req != 0) begin
            rx_hold     <= rx_hold_req;
            rx_hold_req = 0;
            i_ready     <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap  <= rx_gap - 1;
            i_ready <= 1'b0;
        end else if (rx_quiet) begin
            i_ready <= 1'b1;
        end else begin
            gap = draw_gap();
            if (gap == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                rx_gap  <= gap - 1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_admit_result want;
        t_admit_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_accepted, o_assigned_id, o_bucket_index, o_frame_full};
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display({"[%0t] result word with nothing expected: ",
                              "acc=%0b id=%0d cell=%0d full=%0b"},
                             $realtime, got.accepted, got.assigned_id, got.bucket_index,
                             got.frame_full);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"[%0t] result %0d: acc %0b/%0b id %0d/%0d ",
                                  "cell %0d/%0d full %0b/%0b (exp/act)"},
                                 $realtime, results_checked,
                                 want.accepted, got.accepted,
                                 want.assigned_id, got.assigned_id,
                                 want.bucket_index, got.bucket_index,
                                 want.frame_full, got.frame_full);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        grid_cfg       = '{IMG_W_RST, IMG_H_RST, PBL_RST, TOTAL_RST};
        foreach (cell_fill[k]) cell_fill[k] = '0;
        frame_admitted = '0;
        id_counter     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_grid();
        test_limit_extremes();
        test_backpressure();
        test_random_phases();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d points in %0d frames over %0d register settings, %0d admitted",
                 points_sent, frames_started, settings_used, points_admitted);
        $display("checked %0d result words, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
